@@ rtl/vcc_pkg.sv @@
// Shared types, constants and helper functions of the view camera controller.
`timescale 1ns / 1ps
package vcc_pkg;

  // Fixed-point format of positions, zoom, angles and times.
  localparam int FRAC_BITS = 16;
  localparam int TRIG_FRAC = 30;

  // Action codes carried in the input item.
  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_PAN       = 3'd1;
  localparam logic [2:0] ACT_ROTATE    = 3'd2;
  localparam logic [2:0] ACT_ZOOM_AT   = 3'd3;
  localparam logic [2:0] ACT_RESET     = 3'd4;
  localparam logic [2:0] ACT_SCREEN2W  = 3'd5;
  localparam logic [2:0] ACT_LOAD_INIT = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WIN_W     = 3'd0;
  localparam logic [2:0] CFG_WIN_H     = 3'd1;
  localparam logic [2:0] CFG_SPEED     = 3'd2;
  localparam logic [2:0] CFG_INIT_X    = 3'd3;
  localparam logic [2:0] CFG_INIT_Y    = 3'd4;
  localparam logic [2:0] CFG_INIT_ZOOM = 3'd5;

  localparam logic [13:0] WIN_W_DEFAULT   = 14'd1280;
  localparam logic [13:0] WIN_H_DEFAULT   = 14'd720;
  localparam logic [23:0] SPEED_RESET     = 24'(15 << FRAC_BITS);
  localparam logic [22:0] INIT_ZOOM_RESET = 23'(1 << FRAC_BITS);

  localparam logic [23:0] ZOOM_ONE = 24'(1 << FRAC_BITS);
  localparam logic [23:0] ZOOM_MIN = 24'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [23:0] ZOOM_MAX = 24'(100 << FRAC_BITS);

  localparam logic signed [63:0] POS_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [63:0] POS_MIN = -POS_MAX - 64'sd1;
  localparam logic signed [63:0] ANG_MAX = (64'sd1 <<< 31) - 64'sd1;
  localparam logic signed [63:0] ANG_MIN = -ANG_MAX - 64'sd1;

  // Shared multiplier: a is consumed in chunks, most significant first.
  localparam int MUL_A_W     = 64;
  localparam int MUL_B_W     = 32;
  localparam int MUL_CHUNK_W = 16;
  localparam int MUL_STEPS   = MUL_A_W / MUL_CHUNK_W;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  // Shared divider: computes num * 2^FRAC_BITS / den, one quotient bit per cycle.
  localparam int DIV_N_W = 36;
  localparam int DIV_D_W = 24;
  localparam int DIV_Q_W = DIV_N_W + FRAC_BITS;

  // CORDIC: angles in degrees with DEG_FRAC fraction bits.
  localparam int CS_W         = 36;
  localparam int CS_U_W       = 41;
  localparam int CS_ITERS     = 24;
  localparam int CS_RED_STEPS = 8;
  localparam int DEG_FRAC     = 24;
  localparam int DEG_SHIFT    = DEG_FRAC - FRAC_BITS;
  localparam logic [CS_U_W-1:0] CS_FULL    = CS_U_W'(64'd360 << DEG_FRAC);
  localparam logic signed [CS_W-1:0] CS_FULL_S    = CS_W'(64'd360 << DEG_FRAC);
  localparam logic signed [CS_W-1:0] CS_HALF_S    = CS_W'(64'd180 << DEG_FRAC);
  localparam logic signed [CS_W-1:0] CS_QUARTER_S = CS_W'(64'd90 << DEG_FRAC);
  localparam logic signed [CS_W-1:0] CS_X0        = CS_W'(64'd652032874);

  typedef struct packed {
    logic [2:0]         action;
    logic [23:0]        delta_time;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] angle_step;
    logic [23:0]        zoom_factor;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] world_x;
    logic signed [47:0] world_y;
  } out_item_t;

  typedef struct packed {
    logic               go;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               go;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic               go;
    logic signed [31:0] angle;
  } cs_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [CS_W-1:0] cos_v;
    logic signed [CS_W-1:0] sin_v;
  } cs_rsp_t;

  function automatic logic signed [47:0] sat_pos(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
    return r[47:0];
  endfunction

  function automatic logic signed [31:0] sat_ang(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > ANG_MAX) ? ANG_MAX : ((v < ANG_MIN) ? ANG_MIN : v);
    return r[31:0];
  endfunction

  function automatic logic [23:0] clamp_zoom(input logic signed [63:0] v);
    logic [23:0] r;
    if (v < signed'(64'(ZOOM_MIN))) begin
      r = ZOOM_MIN;
    end else if (v > signed'(64'(ZOOM_MAX))) begin
      r = ZOOM_MAX;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Arctangent of 2^-i in degrees with DEG_FRAC fraction bits.
  function automatic logic [29:0] atan_deg(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd754974720;
      5'd1:  r = 30'd445687602;
      5'd2:  r = 30'd235489088;
      5'd3:  r = 30'd119537938;
      5'd4:  r = 30'd60000934;
      5'd5:  r = 30'd30029717;
      5'd6:  r = 30'd15018523;
      5'd7:  r = 30'd7509720;
      5'd8:  r = 30'd3754917;
      5'd9:  r = 30'd1877466;
      5'd10: r = 30'd938734;
      5'd11: r = 30'd469367;
      5'd12: r = 30'd234684;
      5'd13: r = 30'd117342;
      5'd14: r = 30'd58671;
      5'd15: r = 30'd29335;
      5'd16: r = 30'd14668;
      5'd17: r = 30'd7334;
      5'd18: r = 30'd3667;
      5'd19: r = 30'd1833;
      5'd20: r = 30'd917;
      5'd21: r = 30'd458;
      5'd22: r = 30'd229;
      5'd23: r = 30'd115;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/view_camera_controller_core.sv @@
// Top level of the view camera controller: sequencer, camera state and configuration.
`timescale 1ns / 1ps
// The controller keeps a current and a target camera position, zoom and rotation, all
// fixed point with 16 fraction bits, and executes one action per command. A command is
// taken when start is high while busy is low; busy then stays high until the action is
// finished, and the next command can be issued as soon as busy is low. Only the
// screen-to-world action produces a result: world_x and world_y appear on out_item,
// flagged by out_strobe for exactly one cycle, and the receiver has no way to stall that
// transfer, so it must capture the result in that cycle. Rotate, reset view, load initial
// and the unused code finish in the decode state, as does a tick with zero elapsed time;
// any other tick makes four passes through the shared multiplier, which works on one
// 16-bit chunk per cycle. Zoom-at uses the multiplier, then the shared divider, then the
// multiplier twice; pan uses the divider twice, and screen-to-world runs the CORDIC for
// the cosine and sine, then four multiplications and two divisions. The divider yields
// one quotient bit per cycle. The configuration port is always ready and is meant to be
// written only while busy is low.
module view_camera_controller_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  vcc_pkg::in_item_t  in_item,
  output logic               busy,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  output logic               out_strobe,
  output vcc_pkg::out_item_t out_item
);

  typedef enum logic [18:0] {
    ST_IDLE      = 19'h00001,
    ST_DECODE    = 19'h00002,
    ST_LERP_GO   = 19'h00004,
    ST_LERP_WAIT = 19'h00008,
    ST_PAN_GO    = 19'h00010,
    ST_PAN_WAIT  = 19'h00020,
    ST_ZM_GO     = 19'h00040,
    ST_ZM_WAIT   = 19'h00080,
    ST_ZR_GO     = 19'h00100,
    ST_ZR_WAIT   = 19'h00200,
    ST_ZP_GO     = 19'h00400,
    ST_ZP_WAIT   = 19'h00800,
    ST_CS_GO     = 19'h01000,
    ST_CS_WAIT   = 19'h02000,
    ST_ROT_GO    = 19'h04000,
    ST_ROT_WAIT  = 19'h08000,
    ST_WD_GO     = 19'h10000,
    ST_WD_WAIT   = 19'h20000,
    ST_OUT       = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [13:0]        win_w_r, win_h_r;
  logic [23:0]        speed_r;
  logic signed [47:0] init_x_r, init_y_r;
  logic [22:0]        init_zoom_r;

  // Camera state.
  logic signed [47:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic [23:0]        cur_zoom_r, goal_zoom_r;
  logic signed [31:0] cur_angle_r, goal_angle_r;

  // Command and scratch registers.
  vcc_pkg::in_item_t  req_r;
  vcc_pkg::out_item_t out_item_r;
  logic [1:0]         idx_r;
  logic               neg_r;
  logic [16:0]        t_r;
  logic [23:0]        old_zoom_r;
  logic [31:0]        ratio_r;
  logic signed [39:0] rx_r, ry_r;

  vcc_pkg::mul_req_t mul_req;
  vcc_pkg::mul_rsp_t mul_rsp;
  vcc_pkg::div_req_t div_req;
  vcc_pkg::div_rsp_t div_rsp;
  vcc_pkg::cs_req_t  cs_req;
  vcc_pkg::cs_rsp_t  cs_rsp;

  vcc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  vcc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  vcc_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(cs_req), .rsp(cs_rsp));

  // Blend factor for a tick: t = min(1.0, dt * speed).
  logic [47:0] t_prod;
  logic [31:0] t_full;
  logic [16:0] t_nxt;

  assign t_prod = 48'(req_r.delta_time) * 48'(speed_r);
  assign t_full = t_prod[vcc_pkg::FRAC_BITS +: 32];
  assign t_nxt  = (t_full > 32'(vcc_pkg::ZOOM_ONE)) ? 17'(vcc_pkg::ZOOM_ONE) : t_full[16:0];

  // Screen point relative to the window center, with y pointing up.
  logic [13:0]        w_eff, h_eff;
  logic signed [33:0] dx, dy;

  assign w_eff = (win_w_r == 14'd0) ? vcc_pkg::WIN_W_DEFAULT : win_w_r;
  assign h_eff = (win_h_r == 14'd0) ? vcc_pkg::WIN_H_DEFAULT : win_h_r;
  assign dx = 34'(req_r.point_x) - signed'(34'(w_eff) << (vcc_pkg::FRAC_BITS - 1));
  assign dy = signed'(34'(h_eff) << (vcc_pkg::FRAC_BITS - 1)) - 34'(req_r.point_y);

  // Differences that feed the multiplier.
  logic signed [49:0] lerp_diff, zp_diff;

  always_comb begin
    unique case (idx_r)
      2'd0: lerp_diff = 50'(goal_x_r) - 50'(cur_x_r);
      2'd1: lerp_diff = 50'(goal_y_r) - 50'(cur_y_r);
      2'd2: lerp_diff = signed'(50'(goal_zoom_r)) - signed'(50'(cur_zoom_r));
      default: lerp_diff = 50'(goal_angle_r) - 50'(cur_angle_r);
    endcase
    zp_diff = (idx_r == 2'd0) ? 50'(req_r.point_x) - 50'(goal_x_r)
                              : 50'(req_r.point_y) - 50'(goal_y_r);
  end

  // Operand selection for the shared units: signed operands are split into a sign and
  // magnitudes, and the sign is applied again to the truncated result.
  logic signed [63:0] op_a_s;
  logic signed [35:0] op_b_s;
  logic [23:0]        op_den;
  logic [63:0]        a_mag;
  logic [35:0]        b_mag;
  logic               op_neg;

  always_comb begin
    op_a_s = '0;
    op_b_s = '0;
    op_den = cur_zoom_r;
    unique case (state_r)
      ST_LERP_GO: begin
        op_a_s = 64'(lerp_diff);
        op_b_s = 36'(t_r);
      end
      ST_ZM_GO: begin
        op_a_s = 64'(goal_zoom_r);
        op_b_s = 36'(req_r.zoom_factor);
      end
      ST_ZP_GO: begin
        op_a_s = 64'(zp_diff);
        op_b_s = 36'(ratio_r);
      end
      ST_ROT_GO: begin
        op_a_s = idx_r[0] ? 64'(dy) : 64'(dx);
        op_b_s = (idx_r == 2'd0 || idx_r == 2'd3) ? cs_rsp.cos_v : cs_rsp.sin_v;
      end
      ST_PAN_GO: begin
        op_a_s = (idx_r == 2'd0) ? 64'(req_r.offset_x) : 64'(req_r.offset_y);
        op_den = goal_zoom_r;
      end
      ST_ZR_GO: begin
        op_a_s = 64'(old_zoom_r);
        op_den = goal_zoom_r;
      end
      ST_WD_GO: begin
        op_a_s = (idx_r == 2'd0) ? 64'(rx_r) : 64'(ry_r);
        op_den = cur_zoom_r;
      end
      default: begin
        op_a_s = '0;
      end
    endcase
    a_mag  = op_a_s[63] ? unsigned'(-op_a_s) : unsigned'(op_a_s);
    b_mag  = op_b_s[35] ? unsigned'(-op_b_s) : unsigned'(op_b_s);
    op_neg = op_a_s[63] ^ op_b_s[35];
  end

  always_comb begin
    mul_req.go = (state_r == ST_LERP_GO) || (state_r == ST_ZM_GO) ||
                 (state_r == ST_ZP_GO) || (state_r == ST_ROT_GO);
    mul_req.a  = a_mag;
    mul_req.b  = b_mag[31:0];
    div_req.go  = (state_r == ST_PAN_GO) || (state_r == ST_ZR_GO) || (state_r == ST_WD_GO);
    div_req.num = a_mag[vcc_pkg::DIV_N_W-1:0];
    div_req.den = op_den;
    cs_req.go    = (state_r == ST_CS_GO);
    cs_req.angle = cur_angle_r;
  end

  // Signed results of the shared units, truncated toward zero.
  logic [vcc_pkg::MUL_P_W-1:0] p_sh;
  logic signed [63:0]          mul_val, div_val;

  always_comb begin
    p_sh    = (state_r == ST_ROT_WAIT) ? (mul_rsp.prod >> vcc_pkg::TRIG_FRAC)
                                       : (mul_rsp.prod >> vcc_pkg::FRAC_BITS);
    mul_val = neg_r ? -signed'(p_sh[63:0]) : signed'(p_sh[63:0]);
    div_val = neg_r ? -signed'(64'(div_rsp.quo)) : signed'(64'(div_rsp.quo));
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_DECODE;
      ST_DECODE: begin
        unique case (req_r.action)
          vcc_pkg::ACT_TICK:
            state_nxt = (req_r.delta_time == 24'd0) ? ST_IDLE : ST_LERP_GO;
          vcc_pkg::ACT_PAN:      state_nxt = ST_PAN_GO;
          vcc_pkg::ACT_ZOOM_AT:  state_nxt = ST_ZM_GO;
          vcc_pkg::ACT_SCREEN2W: state_nxt = ST_CS_GO;
          default:               state_nxt = ST_IDLE;
        endcase
      end
      ST_LERP_GO: state_nxt = ST_LERP_WAIT;
      ST_LERP_WAIT: if (mul_rsp.done) state_nxt = (idx_r == 2'd3) ? ST_IDLE : ST_LERP_GO;
      ST_PAN_GO: state_nxt = ST_PAN_WAIT;
      ST_PAN_WAIT: if (div_rsp.done) state_nxt = (idx_r == 2'd1) ? ST_IDLE : ST_PAN_GO;
      ST_ZM_GO: state_nxt = ST_ZM_WAIT;
      ST_ZM_WAIT: if (mul_rsp.done) state_nxt = ST_ZR_GO;
      ST_ZR_GO: state_nxt = ST_ZR_WAIT;
      ST_ZR_WAIT: if (div_rsp.done) state_nxt = ST_ZP_GO;
      ST_ZP_GO: state_nxt = ST_ZP_WAIT;
      ST_ZP_WAIT: if (mul_rsp.done) state_nxt = (idx_r == 2'd1) ? ST_IDLE : ST_ZP_GO;
      ST_CS_GO: state_nxt = ST_CS_WAIT;
      ST_CS_WAIT: if (cs_rsp.done) state_nxt = ST_ROT_GO;
      ST_ROT_GO: state_nxt = ST_ROT_WAIT;
      ST_ROT_WAIT: if (mul_rsp.done) state_nxt = (idx_r == 2'd3) ? ST_WD_GO : ST_ROT_GO;
      ST_WD_GO: state_nxt = ST_WD_WAIT;
      ST_WD_WAIT: if (div_rsp.done) state_nxt = (idx_r == 2'd1) ? ST_OUT : ST_WD_GO;
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Register file, camera state and per-step write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      win_w_r      <= vcc_pkg::WIN_W_DEFAULT;
      win_h_r      <= vcc_pkg::WIN_H_DEFAULT;
      speed_r      <= vcc_pkg::SPEED_RESET;
      init_x_r     <= '0;
      init_y_r     <= '0;
      init_zoom_r  <= vcc_pkg::INIT_ZOOM_RESET;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      cur_zoom_r   <= vcc_pkg::ZOOM_ONE;
      goal_zoom_r  <= vcc_pkg::ZOOM_ONE;
      cur_angle_r  <= '0;
      goal_angle_r <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        unique case (cfg_index)
          vcc_pkg::CFG_WIN_W:     win_w_r     <= cfg_data[13:0];
          vcc_pkg::CFG_WIN_H:     win_h_r     <= cfg_data[13:0];
          vcc_pkg::CFG_SPEED:     speed_r     <= cfg_data[23:0];
          vcc_pkg::CFG_INIT_X:    init_x_r    <= signed'(cfg_data);
          vcc_pkg::CFG_INIT_Y:    init_y_r    <= signed'(cfg_data);
          vcc_pkg::CFG_INIT_ZOOM: init_zoom_r <= cfg_data[22:0];
          default: ;
        endcase
      end

      if (state_r == ST_IDLE && start) begin
        req_r <= in_item;
      end

      if (mul_req.go || div_req.go) begin
        neg_r <= op_neg;
      end

      unique case (state_r)
        ST_DECODE: begin
          idx_r <= '0;
          t_r   <= t_nxt;
          unique case (req_r.action)
            vcc_pkg::ACT_ROTATE:
              goal_angle_r <= vcc_pkg::sat_ang(64'(goal_angle_r) + 64'(req_r.angle_step));
            vcc_pkg::ACT_RESET: begin
              cur_x_r     <= '0;
              cur_y_r     <= '0;
              goal_x_r    <= '0;
              goal_y_r    <= '0;
              cur_zoom_r  <= vcc_pkg::ZOOM_ONE;
              goal_zoom_r <= vcc_pkg::ZOOM_ONE;
            end
            vcc_pkg::ACT_LOAD_INIT: begin
              cur_x_r     <= init_x_r;
              goal_x_r    <= init_x_r;
              cur_y_r     <= init_y_r;
              goal_y_r    <= init_y_r;
              cur_zoom_r  <= vcc_pkg::clamp_zoom(64'(init_zoom_r));
              goal_zoom_r <= vcc_pkg::clamp_zoom(64'(init_zoom_r));
            end
            default: ;
          endcase
        end
        ST_LERP_WAIT: begin
          if (mul_rsp.done) begin
            idx_r <= idx_r + 1'b1;
            unique case (idx_r)
              2'd0: cur_x_r <= vcc_pkg::sat_pos(64'(cur_x_r) + mul_val);
              2'd1: cur_y_r <= vcc_pkg::sat_pos(64'(cur_y_r) + mul_val);
              2'd2: cur_zoom_r <= vcc_pkg::clamp_zoom(64'(cur_zoom_r) + mul_val);
              default: cur_angle_r <= vcc_pkg::sat_ang(64'(cur_angle_r) + mul_val);
            endcase
          end
        end
        ST_PAN_WAIT: begin
          if (div_rsp.done) begin
            idx_r <= (idx_r == 2'd1) ? 2'd0 : idx_r + 1'b1;
            if (idx_r == 2'd0) begin
              goal_x_r <= vcc_pkg::sat_pos(64'(goal_x_r) + div_val);
            end else begin
              goal_y_r <= vcc_pkg::sat_pos(64'(goal_y_r) + div_val);
            end
          end
        end
        ST_ZM_WAIT: begin
          if (mul_rsp.done) begin
            old_zoom_r  <= goal_zoom_r;
            goal_zoom_r <= vcc_pkg::clamp_zoom(mul_val);
          end
        end
        ST_ZR_WAIT: begin
          if (div_rsp.done) begin
            ratio_r <= div_rsp.quo[31:0];
          end
        end
        ST_ZP_WAIT: begin
          if (mul_rsp.done) begin
            idx_r <= (idx_r == 2'd1) ? 2'd0 : idx_r + 1'b1;
            if (idx_r == 2'd0) begin
              goal_x_r <= vcc_pkg::sat_pos(64'(req_r.point_x) - mul_val);
            end else begin
              goal_y_r <= vcc_pkg::sat_pos(64'(req_r.point_y) - mul_val);
            end
          end
        end
        ST_ROT_WAIT: begin
          if (mul_rsp.done) begin
            idx_r <= idx_r + 1'b1;
            unique case (idx_r)
              2'd0: rx_r <= 40'(mul_val);
              2'd1: rx_r <= rx_r - 40'(mul_val);
              2'd2: ry_r <= 40'(mul_val);
              default: ry_r <= ry_r + 40'(mul_val);
            endcase
          end
        end
        ST_WD_WAIT: begin
          if (div_rsp.done) begin
            idx_r <= (idx_r == 2'd1) ? 2'd0 : idx_r + 1'b1;
            if (idx_r == 2'd0) begin
              out_item_r.world_x <= vcc_pkg::sat_pos(div_val + 64'(cur_x_r));
            end else begin
              out_item_r.world_y <= vcc_pkg::sat_pos(div_val + 64'(cur_y_r));
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = (state_r == ST_OUT);
  assign out_item   = out_item_r;

endmodule

@@ rtl/vcc_mul.sv @@
// Iterative unsigned multiplier that takes one chunk of the first operand per cycle.
`timescale 1ns / 1ps
module vcc_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  vcc_pkg::mul_req_t req,
  output vcc_pkg::mul_rsp_t rsp
);

  logic [vcc_pkg::MUL_A_W-1:0] a_r;
  logic [vcc_pkg::MUL_B_W-1:0] b_r;
  logic [vcc_pkg::MUL_P_W-1:0] acc_r;
  logic [$clog2(vcc_pkg::MUL_STEPS)-1:0] cnt_r;
  logic run_r;
  logic done_r;
  logic [vcc_pkg::MUL_CHUNK_W+vcc_pkg::MUL_B_W-1:0] pp;

  assign pp = a_r[vcc_pkg::MUL_A_W-1 -: vcc_pkg::MUL_CHUNK_W] * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        a_r   <= req.a;
        b_r   <= req.b;
        acc_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        acc_r <= (acc_r << vcc_pkg::MUL_CHUNK_W) + vcc_pkg::MUL_P_W'(pp);
        a_r   <= a_r << vcc_pkg::MUL_CHUNK_W;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $bits(cnt_r)'(vcc_pkg::MUL_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

@@ rtl/vcc_div.sv @@
// Restoring divider that forms num * 2^FRAC_BITS / den one quotient bit per cycle.
`timescale 1ns / 1ps
module vcc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  vcc_pkg::div_req_t req,
  output vcc_pkg::div_rsp_t rsp
);

  logic [vcc_pkg::DIV_Q_W-1:0] dvd_r;
  logic [vcc_pkg::DIV_D_W-1:0] rem_r;
  logic [vcc_pkg::DIV_D_W-1:0] den_r;
  logic [$clog2(vcc_pkg::DIV_Q_W)-1:0] cnt_r;
  logic run_r;
  logic done_r;
  logic [vcc_pkg::DIV_D_W:0] rem_sh;
  logic [vcc_pkg::DIV_D_W:0] rem_sub;
  logic ge;

  assign rem_sh  = {rem_r, dvd_r[vcc_pkg::DIV_Q_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        dvd_r <= vcc_pkg::DIV_Q_W'(req.num) << vcc_pkg::FRAC_BITS;
        rem_r <= '0;
        den_r <= req.den;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? rem_sub[vcc_pkg::DIV_D_W-1:0] : rem_sh[vcc_pkg::DIV_D_W-1:0];
        dvd_r <= {dvd_r[vcc_pkg::DIV_Q_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $bits(cnt_r)'(vcc_pkg::DIV_Q_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r;

endmodule

@@ rtl/vcc_cordic.sv @@
// Iterative CORDIC that reduces an angle in degrees and returns its cosine and sine.
`timescale 1ns / 1ps
module vcc_cordic (
  input  logic             clk,
  input  logic             rst_n,
  input  vcc_pkg::cs_req_t req,
  output vcc_pkg::cs_rsp_t rsp
);

  typedef enum logic [3:0] {
    CS_IDLE   = 4'b0001,
    CS_REDUCE = 4'b0010,
    CS_FOLD   = 4'b0100,
    CS_ITER   = 4'b1000
  } cs_phase_t;

  cs_phase_t phase_r;
  logic [vcc_pkg::CS_U_W-1:0] u_r;
  logic signed [vcc_pkg::CS_W-1:0] x_r, y_r, z_r;
  logic flip_r;
  logic [4:0] cnt_r;
  logic done_r;

  logic signed [vcc_pkg::CS_U_W:0] ang_ext;
  logic signed [vcc_pkg::CS_U_W:0] u_sum;
  logic [vcc_pkg::CS_U_W-1:0] red_sub;
  logic signed [vcc_pkg::CS_W-1:0] z0, z1, z_fold;
  logic fold_flip;
  logic signed [vcc_pkg::CS_W-1:0] sx, sy, at;

  // Bias by a multiple of a full turn so the remainder search works on a positive value.
  assign ang_ext = (vcc_pkg::CS_U_W+1)'(req.angle) <<< vcc_pkg::DEG_SHIFT;
  assign u_sum   = ang_ext +
                   signed'((vcc_pkg::CS_U_W+1)'(vcc_pkg::CS_FULL) << (vcc_pkg::CS_RED_STEPS-1));
  assign red_sub = vcc_pkg::CS_FULL << cnt_r[2:0];

  always_comb begin
    z0 = signed'(u_r[vcc_pkg::CS_W-1:0]);
    z1 = (z0 >= vcc_pkg::CS_HALF_S) ? z0 - vcc_pkg::CS_FULL_S : z0;
    z_fold = z1;
    fold_flip = 1'b0;
    if (z1 > vcc_pkg::CS_QUARTER_S) begin
      z_fold = z1 - vcc_pkg::CS_HALF_S;
      fold_flip = 1'b1;
    end else if (z1 < -vcc_pkg::CS_QUARTER_S) begin
      z_fold = z1 + vcc_pkg::CS_HALF_S;
      fold_flip = 1'b1;
    end
  end

  assign sx = y_r >>> cnt_r;
  assign sy = x_r >>> cnt_r;
  assign at = signed'(vcc_pkg::CS_W'(vcc_pkg::atan_deg(cnt_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= CS_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        CS_IDLE: begin
          if (req.go) begin
            u_r     <= u_sum[vcc_pkg::CS_U_W-1:0];
            cnt_r   <= 5'(vcc_pkg::CS_RED_STEPS - 1);
            phase_r <= CS_REDUCE;
          end
        end
        CS_REDUCE: begin
          if (u_r >= red_sub) begin
            u_r <= u_r - red_sub;
          end
          if (cnt_r == 5'd0) begin
            phase_r <= CS_FOLD;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        CS_FOLD: begin
          x_r     <= vcc_pkg::CS_X0;
          y_r     <= '0;
          z_r     <= z_fold;
          flip_r  <= fold_flip;
          cnt_r   <= '0;
          phase_r <= CS_ITER;
        end
        CS_ITER: begin
          if (z_r >= 0) begin
            x_r <= x_r - sx;
            y_r <= y_r + sy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + sx;
            y_r <= y_r - sy;
            z_r <= z_r + at;
          end
          if (cnt_r == 5'(vcc_pkg::CS_ITERS - 1)) begin
            phase_r <= CS_IDLE;
            done_r  <= 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: phase_r <= CS_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = flip_r ? -x_r : x_r;
  assign rsp.sin_v = flip_r ? -y_r : y_r;

endmodule
